// ===== rtl/core/pdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet delay FIFO package
// Shared sizes, codes and word types for the packet delay FIFO.
// ----------------------------------------------------------------------------
package pdf_pkg;

    // Queue sizing
    localparam int CAPACITY    = 32;
    localparam int FLUSH_COUNT = 16;
    localparam int PTR_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W       = $clog2(CAPACITY + 1);
    localparam int FLUSH_EFF   = (FLUSH_COUNT < CAPACITY) ? FLUSH_COUNT : CAPACITY;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int TAG_W    = 16;
    localparam int NOW_W    = 32;
    localparam int LAG_W    = 12;
    localparam int QUEUED_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Lag limits and reset value
    localparam logic [LAG_W-1:0] LAG_MAX   = 12'd3000;
    localparam logic [LAG_W-1:0] LAG_RESET = 12'd50;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_PACKET = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_IN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_OUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAG       = 2'd3;

    // Command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_QUEUE = 2'd0,
        CMD_PASS  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_FLUSH = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic             enable;
        logic             delay_in;
        logic             delay_out;
        logic [LAG_W-1:0] lag;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [TAG_W-1:0] tag;
        logic [NOW_W-1:0] now;
    } cmd_t;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic                delayed;
        logic [QUEUED_W-1:0] queued_after;
        logic                last;
    } res_t;

endpackage

// ===== rtl/core/packet_delay_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet delay FIFO
// Delays selected packet tags by a configurable lag, passes others through.
// ----------------------------------------------------------------------------
// Sequence: a word waits in the front command queue until the back end takes it,
// which then starts the scan, tests the age of each queued entry, starts the emit
// and sends the result words; a flush starts the emit and sends every queued word.
// Throughput: one input word at a time in the back end; the single-port age scan
// and tag read move one queue entry per cycle; a full result queue stalls the read.
// Reset: rst_n clears queue pointers, occupancy and loads the register defaults.
module packet_delay_fifo
    import pdf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [FUNC_W-1:0]     func,
    input  logic [TAG_W-1:0]      packet_tag,
    input  logic                  inbound,
    input  logic [NOW_W-1:0]      now_ms,
    output logic                  empty,
    input  logic                  pop,
    output logic [TAG_W-1:0]      packet_tag_res,
    output logic                  was_delayed,
    output logic [QUEUED_W-1:0]   queued_after,
    output logic                  last_of_run,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;
    logic res_push;
    logic res_full;
    res_t res_in;
    res_t res_out;

    // Configuration registers; clamp the lag on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable    <= 1'b0;
            cfg_reg.delay_in  <= 1'b1;
            cfg_reg.delay_out <= 1'b1;
            cfg_reg.lag       <= LAG_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_ENABLE:    cfg_reg.enable    <= cfg_wdata[0];
                REG_DELAY_IN:  cfg_reg.delay_in  <= cfg_wdata[0];
                REG_DELAY_OUT: cfg_reg.delay_out <= cfg_wdata[0];
                REG_LAG:
                begin
                    cfg_reg.lag <= (LAG_W'(cfg_wdata) > LAG_MAX) ? LAG_MAX
                                                                 : LAG_W'(cfg_wdata);
                end
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    pdf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .full       (full),
        .func       (func),
        .packet_tag (packet_tag),
        .inbound    (inbound),
        .now_ms     (now_ms),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .cmd        (cmd)
    );

    pdf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .res_push  (res_push),
        .res_full  (res_full),
        .res       (res_in)
    );

    pdf_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_full (res_full),
        .res_in   (res_in),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    assign packet_tag_res = res_out.tag;
    assign was_delayed    = res_out.delayed;
    assign queued_after   = res_out.queued_after;
    assign last_of_run    = res_out.last;

endmodule

// ===== rtl/core/pdf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet delay FIFO front end
// Accepts input words, classifies them into commands and holds them in a
// two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module pdf_front
    import pdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              push,
    output logic              full,
    input  logic [FUNC_W-1:0] func,
    input  logic [TAG_W-1:0]  packet_tag,
    input  logic              inbound,
    input  logic [NOW_W-1:0]  now_ms,
    output logic              cmd_valid,
    input  logic              cmd_pop,
    output cmd_t              cmd
);

    cmd_t       cmd_q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    logic       store;
    logic       sel;
    cmd_t       cmd_in;

    // Classify the incoming word
    always_comb
    begin
        sel         = inbound ? cfg.delay_in : cfg.delay_out;
        cmd_in.tag  = packet_tag;
        cmd_in.now  = now_ms;
        case (func)
            FUNC_PACKET: cmd_in.kind = (cfg.enable && sel) ? CMD_QUEUE : CMD_PASS;
            FUNC_TICK:   cmd_in.kind = CMD_TICK;
            FUNC_FLUSH:  cmd_in.kind = CMD_FLUSH;
            default:     cmd_in.kind = CMD_TICK;
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign accept    = push && !full;
    // Drop the unused function code: accepted, but no command
    assign store     = accept && (func != FUNC_NONE);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = cmd_q_reg[rd_ptr_reg];

    // Advance queue pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (store)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_pop && cmd_valid)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({store, cmd_pop && cmd_valid})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the command words
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            cmd_q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== rtl/core/pdf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet delay FIFO back end
// Owns the delay queue memories; enqueues, scans ages, decides how many entries
// leave and sends result words out one per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module pdf_back
    import pdf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic cmd_valid,
    output logic cmd_pop,
    input  cmd_t cmd,
    output logic res_push,
    input  logic res_full,
    output res_t res
);

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_SCAN_START = 6'b000010,
        ST_SCAN       = 6'b000100,
        ST_EMIT_START = 6'b001000,
        ST_EMIT       = 6'b010000,
        ST_BYPASS     = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] sp_reg, sp_next;
    logic [OCC_W-1:0] cnt_reg, cnt_next;
    logic [OCC_W-1:0] qa_reg, qa_next;
    logic             bypass_reg, bypass_next;
    cmd_t             cmd_reg, cmd_next;

    logic [TAG_W-1:0] tag_mem  [CAPACITY];
    logic [NOW_W-1:0] time_mem [CAPACITY];
    logic [TAG_W-1:0] tag_q;
    logic [NOW_W-1:0] time_q;
    logic             mem_wen;
    logic [PTR_W-1:0] rd_addr;

    logic [NOW_W-1:0] age;
    logic             release_ok;
    logic             forced;
    logic [OCC_W-1:0] n_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    // Wrap-safe age of the entry under scan
    assign age        = cmd_reg.now - time_q;
    assign release_ok = (cnt_reg != occ_reg) && (age > NOW_W'(cfg.lag));
    assign forced     = (cnt_reg == '0) && (occ_reg == OCC_W'(CAPACITY));
    assign n_pop      = forced ? OCC_W'(FLUSH_EFF) : cnt_reg;

    // Sequence one command
    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        sp_next     = sp_reg;
        cnt_next    = cnt_reg;
        qa_next     = qa_reg;
        bypass_next = bypass_reg;
        cmd_next    = cmd_reg;
        cmd_pop     = 1'b0;
        mem_wen     = 1'b0;
        rd_addr     = sp_reg;
        res_push    = 1'b0;
        res.tag          = tag_q;
        res.delayed      = 1'b1;
        res.queued_after = QUEUED_W'(qa_reg);
        res.last         = (cnt_reg == OCC_W'(1)) && !bypass_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    cmd_next    = cmd;
                    bypass_next = 1'b0;
                    cnt_next    = '0;
                    if (cmd.kind == CMD_FLUSH)
                    begin
                        cnt_next   = occ_reg;
                        qa_next    = '0;
                        state_next = (occ_reg != '0) ? ST_EMIT_START : ST_IDLE;
                    end
                    else
                    begin
                        if (cmd.kind == CMD_QUEUE && occ_reg < OCC_W'(CAPACITY))
                        begin
                            mem_wen     = 1'b1;
                            wr_ptr_next = ptr_inc(wr_ptr_reg);
                            occ_next    = occ_reg + 1'b1;
                        end
                        else
                        begin
                            bypass_next = (cmd.kind == CMD_QUEUE) || (cmd.kind == CMD_PASS);
                        end
                        state_next = ST_SCAN_START;
                    end
                end
            end
            ST_SCAN_START:
            begin
                rd_addr    = rd_ptr_reg;
                sp_next    = rd_ptr_reg;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (release_ok)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    sp_next  = ptr_inc(sp_reg);
                    rd_addr  = ptr_inc(sp_reg);
                end
                else
                begin
                    cnt_next = n_pop;
                    qa_next  = occ_reg - n_pop;
                    if (n_pop != '0)
                    begin
                        state_next = ST_EMIT_START;
                    end
                    else
                    begin
                        state_next = bypass_reg ? ST_BYPASS : ST_IDLE;
                    end
                end
            end
            ST_EMIT_START:
            begin
                rd_addr    = rd_ptr_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                res_push = !res_full;
                rd_addr  = res_full ? rd_ptr_reg : ptr_inc(rd_ptr_reg);
                if (!res_full)
                begin
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    occ_next    = occ_reg - 1'b1;
                    cnt_next    = cnt_reg - 1'b1;
                    if (cnt_reg == OCC_W'(1))
                    begin
                        state_next = bypass_reg ? ST_BYPASS : ST_IDLE;
                    end
                end
            end
            ST_BYPASS:
            begin
                res.tag     = cmd_reg.tag;
                res.delayed = 1'b0;
                res.last    = 1'b1;
                res_push    = !res_full;
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            occ_reg    <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            sp_reg     <= '0;
            cnt_reg    <= '0;
            qa_reg     <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            sp_reg     <= sp_next;
            cnt_reg    <= cnt_next;
            qa_reg     <= qa_next;
            bypass_reg <= bypass_next;
        end
    end

    // Latch the command under work
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // Write the queue memories on enqueue, read with registered data
    always_ff @(posedge clk)
    begin
        if (mem_wen)
        begin
            tag_mem[wr_ptr_reg]  <= cmd.tag;
            time_mem[wr_ptr_reg] <= cmd.now;
        end
        tag_q  <= tag_mem[rd_addr];
        time_q <= time_mem[rd_addr];
    end

endmodule

// ===== rtl/core/pdf_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet delay FIFO result queue
// Two-entry queue that parts the back end from the result port.
// ----------------------------------------------------------------------------
module pdf_out_fifo
    import pdf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_push,
    output logic res_full,
    input  res_t res_in,
    output logic empty,
    input  logic pop,
    output res_t res_out
);

    res_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;
    assign res_out  = q_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Hold the result words
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

// ===== rtl/core/pdf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet delay FIFO checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module pdf_checker
    import pdf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  empty,
    input logic                  pop,
    input logic [TAG_W-1:0]      packet_tag_res,
    input logic                  was_delayed,
    input logic [QUEUED_W-1:0]   queued_after,
    input logic                  last_of_run
);

    // Occupancy shown never exceeds the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (queued_after <= QUEUED_W'(CAPACITY)))
        else $error("queued_after above capacity");

    // A passed-through word always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !was_delayed) |-> last_of_run)
        else $error("pass-through word not last of run");

    // Words of one run report the same occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_of_run) |=> (empty || queued_after == $past(queued_after)))
        else $error("occupancy changed within a run");

    // A waiting result word holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(packet_tag_res) && $stable(last_of_run)))
        else $error("waiting result word changed");

endmodule

bind packet_delay_fifo pdf_checker u_pdf_checker (.*);
